// ===== hdl/slr_pkg.sv =====
// slr_pkg: widths, payload structs, codes and control struct of the stereo
// linear resampler. Used by every module under hdl; depends on nothing.

package slr_pkg;

  localparam int PHASE_FRAC_BITS = 24;
  localparam int MAX_RUN         = 16;

  localparam int SAMPLE_W   = 16;
  localparam int STEP_W     = 28;
  localparam int PHASE_W    = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 2;
  localparam int CNT_W      = $clog2(MAX_RUN + 1);
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int PROD_W     = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int ACC_W      = PHASE_FRAC_BITS + 2 * SAMPLE_W;
  localparam int SCALE_SH   = SAMPLE_W - 1;
  localparam int Q_LSB      = PHASE_FRAC_BITS + SCALE_SH;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'd1 << PHASE_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 4'd0,
    CFG_MONO_SOURCE = 4'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    UOP_IDLE,
    UOP_MAC,
    UOP_SCALE
  } unit_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CHECK,
    S_MAC_L,
    S_SCL_L,
    S_MAC_R,
    S_SCL_R,
    S_EMIT
  } seq_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       silent;
    logic                       end_of_packet;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       last_of_run;
  } out_frame_t;

  typedef struct packed {
    unit_op_e                   op;
    logic                       sel_prev;
    logic                       sel_right;
    logic [PHASE_FRAC_BITS-1:0] frac;
    logic                       cap_left;
    logic                       load_out;
    logic                       last;
    logic                       done;
    logic                       busy;
  } seq_ctrl_t;

endpackage

// ===== hdl/stereo_linear_resampler.sv =====
// stereo_linear_resampler: one input frame yields k (0 to 16) output frames;
// input stall stays high while a frame is processed, also while a result is held
// per output: phase check, two multiply-add and two scale passes, output load;
// reset sets phase step 1.0, mono off, phase zero and no previous frame.
// Depends on slr_pkg.

module stereo_linear_resampler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  slr_pkg::in_frame_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output slr_pkg::out_frame_t                out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [slr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [slr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import slr_pkg::*;

  seq_ctrl_t ctrl;

  logic [STEP_W-1:0]          step_q, step_d;
  logic                       mono_q, mono_d;
  logic signed [SAMPLE_W-1:0] cur_l_q, cur_r_q, prev_l_q, prev_r_q;
  logic                       eop_q;
  logic                       have_prev_q;
  logic signed [SAMPLE_W-1:0] left_hold_q;
  logic                       out_valid_q;
  out_frame_t                 out_data_q;

  logic                       in_accept;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] l_in, r_in;
  logic signed [SAMPLE_W-1:0] unit_a, unit_b, unit_q;

  assign in_stall_o  = ctrl.busy;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // silent wins over mono
  assign l_in = in_data_i.silent ? '0 : in_data_i.left_sample;
  assign r_in = in_data_i.silent ? '0 :
                (mono_q ? in_data_i.left_sample : in_data_i.right_sample);

  always_comb begin
    step_d = step_q;
    mono_d = mono_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PHASE_STEP:  step_d = cfg_data_i[STEP_W-1:0];
        CFG_MONO_SOURCE: mono_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // interval source is the previous frame, or the current one held flat
  assign unit_b = ctrl.sel_right ? cur_r_q : cur_l_q;
  assign unit_a = ctrl.sel_prev ? (ctrl.sel_right ? prev_r_q : prev_l_q) : unit_b;

  slr_interp_unit u_unit (
    .clk_i  (clk_i),
    .op_i   (ctrl.op),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .frac_i (ctrl.frac),
    .q_o    (unit_q)
  );

  slr_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .have_prev_i (have_prev_q),
    .eop_i       (eop_q),
    .step_i      (step_q),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      mono_q      <= 1'b0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      mono_q <= mono_d;
      if (ctrl.done) begin
        have_prev_q <= !eop_q;
      end
      if (ctrl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cur_l_q <= l_in;
      cur_r_q <= r_in;
      eop_q   <= in_data_i.end_of_packet;
    end
    if (ctrl.done) begin
      prev_l_q <= eop_q ? '0 : cur_l_q;
      prev_r_q <= eop_q ? '0 : cur_r_q;
    end
    if (ctrl.cap_left) begin
      left_hold_q <= unit_q;
    end
    if (ctrl.load_out) begin
      out_data_q.left_out    <= left_hold_q;
      out_data_q.right_out   <= unit_q;
      out_data_q.last_of_run <= ctrl.last;
    end
  end

endmodule

// ===== hdl/slr_interp_unit.sv =====
// slr_interp_unit: shared multiply-add and scale unit with one accumulator.
// Depends on slr_pkg.

module slr_interp_unit (
  input  logic                                 clk_i,
  input  slr_pkg::unit_op_e                    op_i,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]  a_i,
  input  logic signed [slr_pkg::SAMPLE_W-1:0]  b_i,
  input  logic [slr_pkg::PHASE_FRAC_BITS-1:0]  frac_i,
  output logic signed [slr_pkg::SAMPLE_W-1:0]  q_o
);
  import slr_pkg::*;

  localparam logic signed [ACC_W-1:0] TRUNC_BIAS =
    ACC_W'((64'd1 << Q_LSB) - 64'd1);

  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  mac_val;
  logic signed [ACC_W-1:0]  scale_val;

  assign diff    = {b_i[SAMPLE_W-1], b_i} - {a_i[SAMPLE_W-1], a_i};
  assign prod    = diff * $signed({1'b0, frac_i});
  // a * 2^F + (b - a) * f
  assign mac_val = (ACC_W'(a_i) <<< PHASE_FRAC_BITS) + ACC_W'(prod);
  // times 32767, biased so the final shift rounds toward zero
  assign scale_val = (acc_q <<< SCALE_SH) - acc_q
                   + (acc_q[ACC_W-1] ? TRUNC_BIAS : '0);

  always_comb begin
    case (op_i)
      UOP_IDLE:  acc_d = acc_q;
      UOP_MAC:   acc_d = mac_val;
      UOP_SCALE: acc_d = scale_val;
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign q_o = acc_q[Q_LSB+SAMPLE_W-1:Q_LSB];

endmodule

// ===== hdl/slr_sequencer.sv =====
// slr_sequencer: phase accumulator, run counter and the state machine that
// steps the shared interpolation unit. Depends on slr_pkg.

module slr_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_accept_i,
  input  logic                          have_prev_i,
  input  logic                          eop_i,
  input  logic [slr_pkg::STEP_W-1:0]    step_i,
  input  logic                          out_free_i,
  output slr_pkg::seq_ctrl_t            ctrl_o
);
  import slr_pkg::*;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

  seq_state_e                 state_q, state_d;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       iv_q, iv_d;
  logic [PHASE_FRAC_BITS-1:0] frac_q, frac_d;
  logic                       last_q, last_d;

  logic [PHASE_W-1:0] phase_sum;
  logic [PHASE_W-1:0] phase_end;
  logic [CNT_W-1:0]   cnt_inc;
  logic               in_iv;
  logic               emit_more;
  logic               more_after;
  logic               any_iv;
  logic               next_iv;

  assign phase_sum = phase_q + PHASE_W'(step_i);
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign in_iv     = (phase_q[PHASE_W-1:PHASE_FRAC_BITS] == '0);
  assign emit_more = in_iv && (cnt_q < CNT_W'(MAX_RUN));
  // end of interval: drop one whole frame, never below zero
  assign phase_end = in_iv ? '0 : (phase_q - PHASE_ONE);
  assign any_iv    = have_prev_i || eop_i;
  assign next_iv   = iv_q && eop_i;
  // does another position follow, here or in the packet's own interval
  assign more_after = (cnt_inc < CNT_W'(MAX_RUN)) &&
                      ((phase_sum[PHASE_W-1:PHASE_FRAC_BITS] == '0) ||
                       (next_iv && (phase_sum[PHASE_W-1:PHASE_FRAC_BITS+1] == '0)));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_accept_i) state_d = S_START;
      S_START: state_d = any_iv ? S_CHECK : S_IDLE;
      S_CHECK: begin
        if (emit_more) state_d = S_MAC_L;
        else if (next_iv) state_d = S_CHECK;
        else state_d = S_IDLE;
      end
      S_MAC_L: state_d = S_SCL_L;
      S_SCL_L: state_d = S_MAC_R;
      S_MAC_R: state_d = S_SCL_R;
      S_SCL_R: state_d = S_EMIT;
      S_EMIT:  if (out_free_i) state_d = S_CHECK;
      default: state_d = S_IDLE;
    endcase
  end

  // phase, count and interval bookkeeping
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    iv_d    = iv_q;
    frac_d  = frac_q;
    last_d  = last_q;
    case (state_q)
      S_START: begin
        iv_d  = have_prev_i;
        cnt_d = '0;
      end
      S_CHECK: begin
        if (emit_more) begin
          frac_d  = phase_q[PHASE_FRAC_BITS-1:0];
          phase_d = phase_sum;
          cnt_d   = cnt_inc;
          last_d  = !more_after;
        end else if (next_iv) begin
          iv_d    = 1'b0;
          phase_d = phase_end;
        end else begin
          phase_d = PHASE_W'(phase_end[STEP_W-1:0]);
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.op        = UOP_IDLE;
    ctrl_o.sel_prev  = iv_q;
    ctrl_o.frac      = frac_q;
    ctrl_o.last      = last_q;
    ctrl_o.busy      = (state_q != S_IDLE);
    case (state_q)
      S_START: ctrl_o.done = !any_iv;
      S_CHECK: ctrl_o.done = !emit_more && !next_iv;
      S_MAC_L: ctrl_o.op = UOP_MAC;
      S_SCL_L: ctrl_o.op = UOP_SCALE;
      S_MAC_R: begin
        ctrl_o.op        = UOP_MAC;
        ctrl_o.sel_right = 1'b1;
        ctrl_o.cap_left  = 1'b1;
      end
      S_SCL_R: ctrl_o.op = UOP_SCALE;
      S_EMIT:  ctrl_o.load_out = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= '0;
      cnt_q   <= '0;
      iv_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      iv_q    <= iv_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
  end

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_out |-> out_free_i)
    else $error("result loaded while output register is held");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.done |=> state_q == S_IDLE)
    else $error("item finished but sequencer did not return to idle");

  a_idle_phase_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> phase_q[PHASE_W-1:STEP_W] == '0)
    else $error("phase not wrapped to step width between items");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MAC_L |-> (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_RUN)))
    else $error("run counter outside one to run limit");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.load_out && ctrl_o.last) |=> state_q == S_CHECK && !emit_more)
    else $error("position emitted after the frame flagged last");

endmodule

// ===== sim/stereo_linear_resampler_checker.sv =====
// stereo_linear_resampler_checker: watches the request, result and register
// channels, predicts each output frame and compares it. Depends on slr_pkg.
`timescale 1ns / 1ps

module stereo_linear_resampler_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  slr_pkg::in_frame_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  slr_pkg::out_frame_t            out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [slr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [slr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o
);
  import slr_pkg::*;

  localparam longint unsigned PHASE_ONE = 64'd1 << PHASE_FRAC_BITS;

  logic [STEP_W-1:0] step_reg;
  logic              mono_reg;
  logic [63:0]       phase_acc;
  int                last_left;
  int                last_right;
  bit                holding_frame;
  out_frame_t        expected_frames[$];

  // exact a + (b - a) * frac, clamped, then scaled by 32767/32768 toward zero
  function automatic logic signed [SAMPLE_W-1:0] lerp_sample(int a, int b,
                                                            longint unsigned frac);
    longint lim;
    longint n;
    longint m;
    longint q;
    lim = longint'(32768) * longint'(PHASE_ONE);
    n = longint'(a) * longint'(PHASE_ONE) + longint'(b - a) * longint'(frac);
    if (n > lim) n = lim;
    if (n < -lim) n = -lim;
    m = (n < 0) ? -n : n;
    q = (m * 32767) >> (SCALE_SH + PHASE_FRAC_BITS);
    if (n < 0) q = -q;
    return q[SAMPLE_W-1:0];
  endfunction

  task automatic sweep_interval(int al, int ar, int bl, int br, inout int count);
    out_frame_t r;
    while (phase_acc < PHASE_ONE && count < MAX_RUN) begin
      r.left_out    = lerp_sample(al, bl, phase_acc & (PHASE_ONE - 1));
      r.right_out   = lerp_sample(ar, br, phase_acc & (PHASE_ONE - 1));
      r.last_of_run = 1'b0;
      expected_frames.insert(expected_frames.size(), r);
      count++;
      phase_acc += step_reg;
    end
    // run limit: skip what is left of the interval
    if (phase_acc < PHASE_ONE) phase_acc = PHASE_ONE;
    phase_acc -= PHASE_ONE;
  endtask

  task automatic predict_frame(in_frame_t f);
    int         l;
    int         r;
    int         count;
    count = 0;
    l = int'($signed(f.left_sample));
    r = mono_reg ? l : int'($signed(f.right_sample));
    if (f.silent) begin
      l = 0;
      r = 0;
    end
    if (holding_frame) sweep_interval(last_left, last_right, l, r, count);
    if (f.end_of_packet) begin
      // hold the packet's last frame, then start the next packet fresh
      sweep_interval(l, r, l, r, count);
      holding_frame = 1'b0;
      last_left     = 0;
      last_right    = 0;
    end else begin
      last_left     = l;
      last_right    = r;
      holding_frame = 1'b1;
    end
    phase_acc = 64'(phase_acc[STEP_W-1:0]);
    if (count > 0) begin
      expected_frames[expected_frames.size() - 1].last_of_run = 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_frame_t want;
    if (!rst_ni) begin
      step_reg      = STEP_RESET;
      mono_reg      = 1'b0;
      phase_acc     = '0;
      last_left     = 0;
      last_right    = 0;
      holding_frame = 1'b0;
      expected_frames.delete();
      fail_count_o  = 0;
      checked_o     = 0;
      pending_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_PHASE_STEP:  step_reg = cfg_data_i[STEP_W-1:0];
          CFG_MONO_SOURCE: mono_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          $error("unexpected output frame: left_out %0d right_out %0d",
                 out_data_i.left_out, out_data_i.right_out);
          fail_count_o++;
        end else begin
          want = expected_frames.pop_front();
          if (out_data_i.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_data_i.left_out);
            fail_count_o++;
          end
          if (out_data_i.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out,
                   out_data_i.right_out);
            fail_count_o++;
          end
          if (out_data_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_data_i.last_of_run);
            fail_count_o++;
          end
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) predict_frame(in_data_i);
      pending_o = expected_frames.size();
    end
  end

endmodule

// ===== sim/stereo_linear_resampler_tb.sv =====
// stereo_linear_resampler_tb: drives source frames and register writes into the
// resampler, with random idling on both sides. Depends on slr_pkg, the
// resampler and stereo_linear_resampler_checker.
`timescale 1ns / 1ps

module stereo_linear_resampler_tb;
  import slr_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int RANDOM_PHASES    = 8;
  localparam int FRAMES_PER_PHASE = 28;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  in_frame_t             in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_frame_t            out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int cycles;
  int frames_sent;
  int settings_used;
  bit idle_on;

  always #10 clk_i = ~clk_i;

  stereo_linear_resampler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  stereo_linear_resampler_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[stereo_linear_resampler] ERROR");
      $finish;
    end
  end

  // output back-pressure in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_frame_t make_frame(int l, int r, bit silent, bit eop);
    in_frame_t f;
    f.left_sample   = l[SAMPLE_W-1:0];
    f.right_sample  = r[SAMPLE_W-1:0];
    f.silent        = silent;
    f.end_of_packet = eop;
    return f;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // entered and left at a falling edge; valid stays up for a following request unless a random idle drops it
  task automatic send_frame(in_frame_t f);
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk_i); while (in_stall);
    frames_sent++;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
  endtask

  // registers change only once the block has drained
  task automatic program_setting(logic [STEP_W-1:0] step, bit mono);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_MONO_SOURCE, CFG_DATA_W'(mono));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    in_frame_t         f;
    int                plen;
    int                sent_here;
    logic [STEP_W-1:0] step_pick;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PHASE_STEP;
    cfg_data  = '0;
    idle_on   = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting: unit step, stereo, extremes of the sample range
    send_frame(make_frame(32767, -32768, 0, 0));
    send_frame(make_frame(-32768, 32767, 0, 0));
    send_frame(make_frame(0, -1, 0, 0));
    send_frame(make_frame(-1, 0, 1, 0));
    send_frame(make_frame(12345, -12345, 0, 1));
    // single-frame packets
    send_frame(make_frame(32767, 32767, 0, 1));
    send_frame(make_frame(-32768, -32768, 1, 1));

    // lowest in-range step, mono, silent with mono
    program_setting(STEP_W'(2097152), 1'b1);
    send_frame(make_frame(32767, 5, 0, 0));
    send_frame(make_frame(-32768, 7, 0, 0));
    send_frame(make_frame(100, -100, 1, 0));
    send_frame(make_frame(-5, 0, 0, 1));

    // zero step: every interval is cut by the run limit
    program_setting('0, 1'b0);
    send_frame(make_frame(1000, 2000, 0, 0));
    send_frame(make_frame(-1000, -2000, 0, 0));
    send_frame(make_frame(3, 4, 0, 1));

    // largest 28-bit step, then the highest in-range step
    program_setting('1, 1'b0);
    send_frame(make_frame(20000, -20000, 0, 0));
    send_frame(make_frame(-20000, 20000, 0, 0));
    send_frame(make_frame(7, 8, 0, 0));
    send_frame(make_frame(32767, -32768, 0, 1));
    program_setting(STEP_W'(134217728), 1'b1);
    send_frame(make_frame(-32768, 1, 0, 0));
    send_frame(make_frame(32767, 2, 0, 0));
    send_frame(make_frame(0, 3, 1, 0));
    send_frame(make_frame(-2, 4, 0, 1));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       step_pick = STEP_W'(2097152);
        1:       step_pick = STEP_W'(134217728);
        2:       step_pick = '0;
        3:       step_pick = '1;
        4:       step_pick = STEP_RESET;
        default: step_pick = STEP_W'($urandom_range(2097152, 134217728));
      endcase
      program_setting(step_pick, bit'($urandom_range(0, 1)));
      // one stretch mid-run and the tail run without idling
      idle_on   = !(p == 3 || p == RANDOM_PHASES - 1);
      sent_here = 0;
      while (sent_here < FRAMES_PER_PHASE) begin
        plen = $urandom_range(1, 10);
        for (int k = 0; k < plen && sent_here < FRAMES_PER_PHASE; k++) begin
          f.left_sample   = pick_sample();
          f.right_sample  = pick_sample();
          f.silent        = ($urandom_range(0, 7) == 0);
          f.end_of_packet = (k == plen - 1) || ($urandom_range(0, 19) == 0);
          send_frame(f);
          sent_here++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4 * SETTLE_CYCLES) @(negedge clk_i);

    $display("sent %0d source frames across %0d step/mono settings", frames_sent,
             settings_used);
    $display("compared %0d resampled output frames", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[stereo_linear_resampler] OK");
    end else begin
      $display("[stereo_linear_resampler] ERROR");
    end
    $finish;
  end

endmodule
